FILE: rtl/frc_pkg.sv
`timescale 1ns / 1ps

package frc_pkg;

    // Frame geometry.
    localparam int FRAME_WRAP   = 256;
    localparam int CNT_W        = $clog2(FRAME_WRAP);
    localparam int HEAD_DROP    = 3;
    localparam int TAIL_DROP    = 5;
    localparam int LENGTH_POS   = 5;
    localparam int LENGTH_EXTRA = 11;
    localparam int START_POS    = HEAD_DROP + TAIL_DROP;

    // Byte codes.
    localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
    localparam logic [7:0] CLOSE_BYTE    = 8'h55;

    // CRC-32 constants, reflected form.
    localparam logic [31:0] CRC_POLY_REFLECTED = 32'hEDB88320;
    localparam logic [31:0] CRC_ALL_ONES       = 32'hFFFFFFFF;

    // Output burst for one input byte.
    localparam int BURST_MAX = 6;
    localparam int BEAT_W    = $clog2(BURST_MAX);
    localparam int BCNT_W    = $clog2(BURST_MAX + 1);

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BCNT_W-1:0]         count;
        logic                      frame_end;
    } t_burst;

    // One byte step of the reflected CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/frc_if.sv
`timescale 1ns / 1ps

// Input byte channel.
interface frc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Output byte channel.
interface frc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       last;

    modport source (output valid, output out_byte, output frame_end, output last, input ready);
    modport sink   (input valid, input out_byte, input frame_end, input last, output ready);
endinterface

FILE: rtl/frc_engine.sv
`timescale 1ns / 1ps

module frc_engine import frc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output t_burst     o_burst
);

    logic [CNT_W-1:0]  r_count, n_count;
    logic [7:0]        r_len, n_len;
    logic [TAIL_DROP-1:0][7:0] r_dly, n_dly;
    logic [31:0]       r_crc, n_crc;

    logic [CNT_W:0]    next_pos;
    logic [7:0]        len_eff;
    logic [8:0]        len_need;
    logic              ends;
    logic              has_old;
    logic              is_start;
    logic [7:0]        old_byte;
    logic [31:0]       crc_base;
    logic [31:0]       crc_new;
    logic [31:0]       crc_fin;

    // Frame position and end detection.
    always_comb begin
        next_pos = {1'b0, r_count} + (CNT_W + 1)'(1);
        if (next_pos >= (CNT_W + 1)'(FRAME_WRAP)) begin
            next_pos = '0;
        end
        len_eff  = (r_count == CNT_W'(LENGTH_POS)) ? i_byte : r_len;
        len_need = {1'b0, len_eff} + 9'(LENGTH_EXTRA);
        ends     = (i_byte == CLOSE_BYTE) && (9'(next_pos) >= len_need);
        has_old  = (r_count >= CNT_W'(START_POS));
        is_start = (r_count == CNT_W'(START_POS));
        old_byte = r_dly[TAIL_DROP-1];
    end

    // CRC of the byte leaving the delay line.
    always_comb begin
        crc_base = is_start ? CRC_ALL_ONES : r_crc;
        crc_new  = has_old ? crc_byte(crc_base, old_byte) : r_crc;
        crc_fin  = crc_new ^ CRC_ALL_ONES;
    end

    // Burst of output bytes for this input byte.
    always_comb begin
        o_burst           = '0;
        o_burst.frame_end = ends;
        if (is_start) begin
            o_burst.bytes[0] = PREAMBLE_BYTE;
            o_burst.bytes[1] = PREAMBLE_BYTE;
            o_burst.bytes[2] = PREAMBLE_BYTE;
            o_burst.bytes[3] = old_byte;
            o_burst.count    = BCNT_W'(4);
        end else if (has_old) begin
            o_burst.bytes[0] = old_byte;
            if (ends) begin
                o_burst.bytes[1] = crc_fin[7:0];
                o_burst.bytes[2] = crc_fin[15:8];
                o_burst.bytes[3] = crc_fin[23:16];
                o_burst.bytes[4] = crc_fin[31:24];
                o_burst.bytes[5] = CLOSE_BYTE;
                o_burst.count    = BCNT_W'(BURST_MAX);
            end else begin
                o_burst.count    = BCNT_W'(1);
            end
        end
    end

    // Next state.
    always_comb begin
        n_count = ends ? '0 : next_pos[CNT_W-1:0];
        n_len   = len_eff;
        n_dly   = r_dly;
        if (r_count >= CNT_W'(HEAD_DROP)) begin
            n_dly = {r_dly[TAIL_DROP-2:0], i_byte};
        end
        n_crc = (ends || (next_pos == '0)) ? CRC_ALL_ONES : crc_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
            r_dly   <= '0;
            r_crc   <= CRC_ALL_ONES;
        end else if (i_advance) begin
            r_count <= n_count;
            r_len   <= n_len;
            r_dly   <= n_dly;
            r_crc   <= n_crc;
        end
    end

endmodule

FILE: rtl/frc_serializer.sv
`timescale 1ns / 1ps

module frc_serializer import frc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_burst       i_burst,
    output logic         o_free,
    frc_out_if.source    o_out
);

    logic              r_busy, n_busy;
    logic [BEAT_W-1:0] r_beat, n_beat;
    t_burst            r_burst;

    logic              is_last;
    logic              take;

    // Current beat of the held burst.
    always_comb begin
        is_last         = (BCNT_W'(r_beat) == (r_burst.count - BCNT_W'(1)));
        take            = r_busy && o_out.ready;
        o_out.valid     = r_busy;
        o_out.out_byte  = r_burst.bytes[r_beat];
        o_out.last      = is_last;
        o_out.frame_end = r_burst.frame_end && is_last;
        o_free          = !r_busy || (take && is_last);
    end

    // Beat counter; a new burst loads when idle or as the last beat leaves.
    always_comb begin
        n_busy = r_busy;
        n_beat = r_beat;
        if (i_load) begin
            n_busy = 1'b1;
            n_beat = '0;
        end else if (take) begin
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_beat = r_beat + BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else begin
            r_busy <= n_busy;
            r_beat <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

endmodule

FILE: rtl/frame_reframer_crc32_core.sv
`timescale 1ns / 1ps

// Frame regenerator with fresh CRC-32. Received bytes enter on i_in and
// regenerated frames leave on o_out. An input byte is registered, then
// processed combinationally into a burst of zero, one, four or six output
// bytes, which the output serializer hands out one per cycle while the output
// is ready. The input can take a new byte every cycle while the output keeps
// pace; the byte that starts a frame occupies the output for its burst of four
// bytes and the closing byte for its burst of six, and the serializer's burst
// length sets the rate during those. There is no clearing pass after reset.
module frame_reframer_crc32_core import frc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frc_in_if.sink     i_in,
    frc_out_if.source  o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    t_burst     burst;
    logic       ser_free;
    logic       advance;
    logic       load;

    // Stage hand-off: bytes without output never wait for the serializer.
    always_comb begin
        advance    = r_in_valid && ((burst.count == '0) || ser_free);
        load       = advance && (burst.count != '0);
        i_in.ready = !r_in_valid || advance;
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    frc_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (r_in_byte),
        .i_advance (advance),
        .o_burst   (burst)
    );

    frc_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_burst (burst),
        .o_free  (ser_free),
        .o_out   (o_out)
    );

endmodule

FILE: rtl/frc_checker.sv
`timescale 1ns / 1ps

module frc_checker import frc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_frame_end,
    input logic       i_out_last
);

    // A stalled output request keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_frame_end)
             && $stable(i_out_last)))
        else $error("output request changed while stalled");

    // The closing byte ends the burst of its input byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_frame_end) |-> i_out_last)
        else $error("frame end without last");

    // The closing byte is always the close code.
    a_end_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_frame_end) |-> (i_out_byte == CLOSE_BYTE))
        else $error("frame end on a byte other than the close code");

    // With no output pending the input side never stalls.
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output is empty");

endmodule

bind frame_reframer_crc32_core frc_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_out_frame_end (o_out.frame_end),
    .i_out_last      (o_out.last)
);
